@@ design/pba_pkg.sv @@
// Package for the packed bitfield array: shared widths, codes, reset values
// and the slot location record passed from the locator to the top level.
// No dependencies.
`default_nettype none

package pba_pkg;

  // Default size of the byte store.
  localparam int MEM_BYTES_DEF = 256;

  // Field widths.
  localparam int OP_W    = 2;
  localparam int SLOT_W  = 11;
  localparam int DATA_W  = 8;
  localparam int BPS_W   = 4;
  localparam int COUNT_W = 12;
  localparam int ROW_W   = 16;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register reset values.
  localparam logic [BPS_W-1:0]   BPS_RESET   = 4'd8;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 12'd256;

  // Register indexes, taken from the word address.
  localparam logic REG_BPS   = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CLEAR
  } state_t;

  // Where a slot lies in the two byte banks.
  typedef struct packed {
    logic              oor;       // beyond the slot count or the store
    logic              two;       // slot straddles two bytes
    logic              lo_odd;    // first byte lies in the odd bank
    logic [2:0]        off;       // bit offset within the first byte
    logic [DATA_W-1:0] mask;      // low-order mask of the slot width
    logic [ROW_W-1:0]  even_row;  // row read in the even bank
    logic [ROW_W-1:0]  odd_row;   // row read in the odd bank
  } loc_t;

endpackage

`default_nettype wire

@@ design/pba_bank.sv @@
// One bank of the byte store: a synchronous RAM with one write port and one
// registered read port. No package dependencies.
`default_nettype none

module pba_bank #(
  parameter  int ROWS = 128,
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/pba_locate.sv @@
// Slot locator: works out the bit position of a slot, checks it against the
// slot count and the store size, and gives the bank rows. Uses pba_pkg.
`default_nettype none

module pba_locate #(
  parameter int MEM_BYTES = pba_pkg::MEM_BYTES_DEF
) (
  input  wire logic [pba_pkg::SLOT_W-1:0]  slot,
  input  wire logic [pba_pkg::BPS_W-1:0]   bits_per_slot,
  input  wire logic [pba_pkg::COUNT_W-1:0] slot_count,
  output pba_pkg::loc_t                    loc
);

  logic [3:0]  w;
  logic [14:0] first_bit;
  logic [14:0] last_bit;
  logic [11:0] byte0;
  logic [11:0] last_byte;
  logic [15:0] row;

  always_comb begin
    // Width zero is taken as one and anything above eight as eight.
    if (bits_per_slot == 4'd0) begin
      w = 4'd1;
    end else if (bits_per_slot > 4'd8) begin
      w = 4'd8;
    end else begin
      w = bits_per_slot;
    end

    first_bit = {4'd0, slot} * {11'd0, w};
    last_bit  = first_bit + {11'd0, w} - 15'd1;
    byte0     = first_bit[14:3];
    last_byte = last_bit[14:3];
    row       = {5'd0, byte0[11:1]};

    loc.oor  = ({1'b0, slot} >= slot_count) ||
               ({5'd0, last_byte} >= 17'(MEM_BYTES));
    loc.off  = first_bit[2:0];
    loc.two  = ({1'b0, first_bit[2:0]} + w) > 4'd8;
    loc.lo_odd = byte0[0];
    loc.mask = 8'hFF >> (4'd8 - w);
    // An odd first byte continues in the next row of the even bank.
    loc.even_row = (byte0[0] && loc.two) ? row + 16'd1 : row;
    loc.odd_row  = row;
  end

endmodule

`default_nettype wire

@@ design/packed_bitfield_array.sv @@
// Top level of the packed bitfield array: command channel, APB register port,
// control sequencer and read-modify-write datapath. Uses pba_pkg, pba_locate
// and pba_bank.
//
// Usage. A command beat (op, slot, value) is taken at a rising edge where
// start is high and busy is low. Each command gives exactly one result beat:
// done is high for one cycle with read_value and out_of_range, and the result
// is taken at the edge that ends that cycle; the receiver cannot stall it.
// The store holds MEM_BYTES bytes split into an even and an odd bank, so the
// two bytes a slot may straddle are read in the same cycle.
// Timing. A read or write is looked up at the accept edge, the bank data
// arrives in the following cycle, where the slot is extracted or merged and
// written back, and the result beat follows in the next cycle. Busy is low
// again by then; a new read or write is not taken while the last one is
// still reading the banks, as their read port is registered. A flagged access
// or an unused op code returns its result in the cycle after acceptance.
// A clear sweeps both banks one row per cycle, with the result beat in the
// cycle after the sweep. Reset runs the same sweep with busy high and gives
// no result beat. Registers: bits_per_slot at byte address 0, slot_count
// at byte address 4; they are to be written only while the block is idle.
`default_nettype none

module packed_bitfield_array #(
  parameter int MEM_BYTES = pba_pkg::MEM_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pba_pkg::OP_W-1:0]      op,
  input  wire logic [pba_pkg::SLOT_W-1:0]    slot,
  input  wire logic [pba_pkg::DATA_W-1:0]    value,
  // Result channel
  output logic                               done,
  output logic [pba_pkg::DATA_W-1:0]         read_value,
  output logic                               out_of_range,
  // Register port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pba_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [pba_pkg::PDATA_W-1:0]   pwdata,
  output logic [pba_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  // Each bank holds one byte of every byte pair.
  localparam int ROWS = (MEM_BYTES + 1) / 2;
  localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [pba_pkg::BPS_W-1:0]   bits_per_slot;
  logic [pba_pkg::COUNT_W-1:0] slot_count;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // The two low address bits are ignored; registers are word aligned.
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_slot <= pba_pkg::BPS_RESET;
      slot_count    <= pba_pkg::COUNT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == pba_pkg::REG_BPS) begin
        bits_per_slot <= pwdata[pba_pkg::BPS_W-1:0];
      end else begin
        slot_count <= pwdata[pba_pkg::COUNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == pba_pkg::REG_BPS) begin
      prdata = {{(pba_pkg::PDATA_W - pba_pkg::BPS_W){1'b0}}, bits_per_slot};
    end else begin
      prdata = {{(pba_pkg::PDATA_W - pba_pkg::COUNT_W){1'b0}}, slot_count};
    end
  end

  // ---------------------------------------------------------------------
  // Slot location, worked out from the command ports at acceptance
  // ---------------------------------------------------------------------
  pba_pkg::loc_t loc;

  pba_locate #(
    .MEM_BYTES (MEM_BYTES)
  ) u_locate (
    .slot          (slot),
    .bits_per_slot (bits_per_slot),
    .slot_count    (slot_count),
    .loc           (loc)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  pba_pkg::state_t state;
  pba_pkg::state_t state_next;
  logic            accept;
  logic            clear_last;
  logic [AW-1:0]   clr_cnt;
  logic            clr_op;     // the running sweep was asked for by a command

  assign accept     = start && !busy;
  assign clear_last = (clr_cnt == AW'(ROWS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pba_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    unique case (state)
      pba_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (pba_pkg::op_t'(op) == pba_pkg::OP_CLEAR) begin
            state_next = pba_pkg::ST_CLEAR;
          end else if ((pba_pkg::op_t'(op) == pba_pkg::OP_READ ||
                        pba_pkg::op_t'(op) == pba_pkg::OP_WRITE) && !loc.oor) begin
            state_next = pba_pkg::ST_READ;
          end
        end
      end
      pba_pkg::ST_READ: begin
        state_next = pba_pkg::ST_IDLE;
      end
      pba_pkg::ST_CLEAR: begin
        if (clear_last) begin
          state_next = pba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      clr_op  <= 1'b0;
    end else if (accept && pba_pkg::op_t'(op) == pba_pkg::OP_CLEAR) begin
      clr_cnt <= '0;
      clr_op  <= 1'b1;
    end else if (state == pba_pkg::ST_CLEAR) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Access held for the read-modify-write cycle
  // ---------------------------------------------------------------------
  logic          q_write;
  logic [7:0]    q_value;
  logic [2:0]    q_off;
  logic          q_two;
  logic          q_lo_odd;
  logic [7:0]    q_mask;
  logic [AW-1:0] even_row;
  logic [AW-1:0] odd_row;

  always_ff @(posedge clk) begin
    if (accept) begin
      q_write  <= (pba_pkg::op_t'(op) == pba_pkg::OP_WRITE);
      q_value  <= value;
      q_off    <= loc.off;
      q_two    <= loc.two;
      q_lo_odd <= loc.lo_odd;
      q_mask   <= loc.mask;
      even_row <= loc.even_row[AW-1:0];
      odd_row  <= loc.odd_row[AW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Byte banks
  // ---------------------------------------------------------------------
  logic          clearing;
  logic          rmw_write;
  logic          even_we;
  logic          odd_we;
  logic [AW-1:0] even_waddr;
  logic [AW-1:0] odd_waddr;
  logic [7:0]    even_wdata;
  logic [7:0]    odd_wdata;
  logic [7:0]    even_rdata;
  logic [7:0]    odd_rdata;

  pba_bank #(
    .ROWS (ROWS)
  ) u_even (
    .clk   (clk),
    .we    (even_we),
    .waddr (even_waddr),
    .wdata (even_wdata),
    .raddr (loc.even_row[AW-1:0]),
    .rdata (even_rdata)
  );

  pba_bank #(
    .ROWS (ROWS)
  ) u_odd (
    .clk   (clk),
    .we    (odd_we),
    .waddr (odd_waddr),
    .wdata (odd_wdata),
    .raddr (loc.odd_row[AW-1:0]),
    .rdata (odd_rdata)
  );

  // ---------------------------------------------------------------------
  // Forwarding: a write lands at the edge that ends the read-modify-write
  // cycle, and busy keeps the next access from issuing its read until the
  // edge after that, so the bank already returns the new byte. The written
  // byte is also held for one cycle and replaces the bank data when the
  // rows match.
  // ---------------------------------------------------------------------
  logic          fwd_even_valid;
  logic          fwd_odd_valid;
  logic [AW-1:0] fwd_even_row;
  logic [AW-1:0] fwd_odd_row;
  logic [7:0]    fwd_even_data;
  logic [7:0]    fwd_odd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_even_valid <= 1'b0;
      fwd_odd_valid  <= 1'b0;
    end else begin
      fwd_even_valid <= even_we && !clearing;
      fwd_odd_valid  <= odd_we && !clearing;
    end
  end

  always_ff @(posedge clk) begin
    fwd_even_row  <= even_row;
    fwd_odd_row   <= odd_row;
    fwd_even_data <= even_wdata;
    fwd_odd_data  <= odd_wdata;
  end

  // ---------------------------------------------------------------------
  // Extract and merge
  // ---------------------------------------------------------------------
  logic [7:0]  even_byte;
  logic [7:0]  odd_byte;
  logic [7:0]  lo_byte;
  logic [7:0]  hi_byte;
  logic [15:0] word;
  logic [15:0] shifted;
  logic [15:0] field_mask;
  logic [15:0] field_val;
  logic [15:0] new_word;
  logic [7:0]  slot_val;

  always_comb begin
    even_byte = (fwd_even_valid && fwd_even_row == even_row) ? fwd_even_data : even_rdata;
    odd_byte  = (fwd_odd_valid && fwd_odd_row == odd_row) ? fwd_odd_data : odd_rdata;
    lo_byte   = q_lo_odd ? odd_byte : even_byte;
    hi_byte   = q_lo_odd ? even_byte : odd_byte;
    word      = {(q_two ? hi_byte : 8'h00), lo_byte};

    shifted  = word >> q_off;
    slot_val = shifted[7:0] & q_mask;

    field_mask = {8'h00, q_mask} << q_off;
    field_val  = {8'h00, q_value & q_mask} << q_off;
    new_word   = (word & ~field_mask) | field_val;
  end

  // Write-back in the ST_READ cycle of a write; the sweep owns the banks
  // while clearing.
  always_comb begin
    clearing  = (state == pba_pkg::ST_CLEAR);
    rmw_write = (state == pba_pkg::ST_READ) && q_write;

    even_we = clearing || (rmw_write && (!q_lo_odd || q_two));
    odd_we  = clearing || (rmw_write && (q_lo_odd || q_two));

    even_waddr = clearing ? clr_cnt : even_row;
    odd_waddr  = clearing ? clr_cnt : odd_row;

    if (clearing) begin
      even_wdata = 8'h00;
      odd_wdata  = 8'h00;
    end else if (q_lo_odd) begin
      even_wdata = new_word[15:8];
      odd_wdata  = new_word[7:0];
    end else begin
      even_wdata = new_word[7:0];
      odd_wdata  = new_word[15:8];
    end
  end

  // ---------------------------------------------------------------------
  // Result beat
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (accept && pba_pkg::op_t'(op) != pba_pkg::OP_CLEAR &&
          (pba_pkg::op_t'(op) == pba_pkg::OP_NOP || loc.oor)) begin
        done <= 1'b1;
      end else if (state == pba_pkg::ST_READ) begin
        done <= 1'b1;
      end else if (clearing && clear_last && clr_op) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value   <= 8'h00;
      out_of_range <= (pba_pkg::op_t'(op) == pba_pkg::OP_READ ||
                       pba_pkg::op_t'(op) == pba_pkg::OP_WRITE) && loc.oor;
    end else if (state == pba_pkg::ST_READ) begin
      read_value   <= q_write ? 8'h00 : slot_val;
      out_of_range <= 1'b0;
    end else if (clearing) begin
      read_value   <= 8'h00;
      out_of_range <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ tb/pba_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the packed bitfield array: follows the command, register and
// result channels, keeps a shadow byte store and registers, and checks every
// result beat in order. Uses pba_pkg.
module pba_checker #(
  parameter int MEM_BYTES = pba_pkg::MEM_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [pba_pkg::OP_W-1:0]      op,
  input  logic [pba_pkg::SLOT_W-1:0]    slot,
  input  logic [pba_pkg::DATA_W-1:0]    value,
  input  logic                          done,
  input  logic [pba_pkg::DATA_W-1:0]    read_value,
  input  logic                          out_of_range,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pba_pkg::PADDR_W-1:0]   paddr,
  input  logic [pba_pkg::PDATA_W-1:0]   pwdata,
  input  logic                          pready,
  output int                            errors,
  output int                            pending
);
  import pba_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              out_of_range;
  } slot_result_t;

  logic [DATA_W-1:0]  shadow_store [MEM_BYTES];
  logic [BPS_W-1:0]   shadow_bps;
  logic [COUNT_W-1:0] shadow_count;
  slot_result_t       awaited_q [$];
  int                 fail_count = 0;

  // Runs one command against the shadow store and returns the result it owes.
  function automatic slot_result_t apply_command(input op_t cmd,
                                                 input logic [SLOT_W-1:0] idx,
                                                 input logic [DATA_W-1:0] data);
    slot_result_t res;
    int unsigned  width, first_bit, byte0, off;
    logic [15:0]  word, field_mask;
    res = '0;
    width = (shadow_bps == 0) ? 1 : (shadow_bps > 8) ? 8 : shadow_bps;
    field_mask = (16'd1 << width) - 16'd1;
    case (cmd)
      OP_CLEAR: begin
        foreach (shadow_store[i]) shadow_store[i] = '0;
      end
      OP_READ, OP_WRITE: begin
        first_bit = idx * width;
        if (idx >= shadow_count || ((first_bit + width - 1) >> 3) >= MEM_BYTES) begin
          res.out_of_range = 1'b1;
        end else begin
          byte0 = first_bit >> 3;
          off = first_bit & 7;
          word = {8'h00, shadow_store[byte0]};
          if (off + width > 8) word[15:8] = shadow_store[byte0 + 1];
          if (cmd == OP_READ) begin
            word = (word >> off) & field_mask;
            res.read_value = word[DATA_W-1:0];
          end else begin
            word = (word & ~(field_mask << off)) | ((16'(data) & field_mask) << off);
            shadow_store[byte0] = word[7:0];
            if (off + width > 8) shadow_store[byte0 + 1] = word[15:8];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    slot_result_t want;
    if (rst) begin
      foreach (shadow_store[i]) shadow_store[i] = '0;
      shadow_bps = BPS_RESET;
      shadow_count = COUNT_RESET;
      awaited_q.delete();
    end else begin
      // A result beat settles the oldest outstanding command first.
      if (done === 1'b1) begin
        if (awaited_q.size() == 0) begin
          $error("result beat with no command outstanding");
          fail_count++;
        end else begin
          want = awaited_q.pop_front();
          if (read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, read_value);
            fail_count++;
          end
          if (out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0d, got %0d", want.out_of_range,
                   out_of_range);
            fail_count++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_BPS:   shadow_bps = pwdata[BPS_W-1:0];
          REG_COUNT: shadow_count = pwdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (start === 1'b1 && busy === 1'b0) begin
        awaited_q.push_back(apply_command(op_t'(op), slot, value));
      end
    end
    errors <= fail_count;
    pending <= awaited_q.size();
  end

endmodule

@@ tb/tb_packed_bitfield_array.sv @@
`timescale 1ns / 100ps
// Testbench top for the packed bitfield array: clock, reset, command and
// register stimulus, and the verdict. Uses pba_pkg, packed_bitfield_array
// and pba_checker.
module tb_packed_bitfield_array;
  import pba_pkg::*;

  localparam int MEM_BYTES = MEM_BYTES_DEF;
  localparam logic [PADDR_W-1:0] ADDR_BPS   = {REG_BPS, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_COUNT = {REG_COUNT, 2'b00};
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BEATS   = 165;

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     op;
  logic [SLOT_W-1:0]   slot;
  logic [DATA_W-1:0]   value;
  logic                done;
  logic [DATA_W-1:0]   read_value;
  logic                out_of_range;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  int                  errors;
  int                  pending;

  // Stimulus shaping: reach is the number of slots that are both below the
  // slot count and inside the store, and window is the base of a small group
  // of slots that most beats hammer, so that reads find data written earlier.
  int unsigned reach;
  int unsigned window;

  always #5 clk = ~clk;

  packed_bitfield_array u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .slot         (slot),
    .value        (value),
    .done         (done),
    .read_value   (read_value),
    .out_of_range (out_of_range),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  pba_checker #(.MEM_BYTES(MEM_BYTES)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .slot         (slot),
    .value        (value),
    .done         (done),
    .read_value   (read_value),
    .out_of_range (out_of_range),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .errors       (errors),
    .pending      (pending)
  );

  // Drops start and waits until every result beat owed has arrived and the
  // block is no longer busy. The count of owed beats is updated by the
  // checker at the edge, so the task waits for an edge before it reads it.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  // An APB write: a setup cycle, then an access cycle that ends at the edge
  // where the register is taken.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Registers are only written once the block has gone quiet. The upper bits
  // of each data word are random, since the block keeps only the low bits.
  task automatic set_config(input logic [BPS_W-1:0] bps, input logic [COUNT_W-1:0] count);
    logic [PDATA_W-1:0] data;
    int unsigned        width, capacity;
    drain();
    data = $urandom;
    data[BPS_W-1:0] = bps;
    write_reg(ADDR_BPS, data);
    data = $urandom;
    data[COUNT_W-1:0] = count;
    write_reg(ADDR_COUNT, data);
    width = (bps == 0) ? 1 : (bps > 8) ? 8 : bps;
    capacity = MEM_BYTES * 8 / width;
    reach = (count < capacity) ? count : capacity;
    window = (reach > 16) ? $urandom_range(0, reach - 16) : 0;
  endtask

  // Offers one command beat and returns at the edge that takes it, with start
  // still high so that a following beat can go straight out.
  task automatic issue(input op_t cmd, input logic [SLOT_W-1:0] idx,
                       input logic [DATA_W-1:0] data);
    start <= 1'b1;
    op <= cmd;
    slot <= idx;
    value <= data;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // A burst of idle cycles with junk on the command fields.
  task automatic rest(input int unsigned cycles);
    start <= 1'b0;
    op <= $urandom_range(0, 3);
    slot <= $urandom_range(0, 2047);
    value <= $urandom_range(0, 255);
    repeat (cycles) @(posedge clk);
  endtask

  // One random command. Most slots are legal, and many of those fall in the
  // small window; the rest probe the top edge of the legal range, just past
  // it, and anywhere in the slot field.
  task automatic random_beat(input bit allow_gaps);
    op_t               cmd;
    logic [SLOT_W-1:0] idx;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    cmd = (pick < 46) ? OP_READ : (pick < 92) ? OP_WRITE : (pick < 96) ? OP_CLEAR : OP_NOP;
    pick = $urandom_range(0, 99);
    if (reach == 0 || pick >= 85) begin
      idx = $urandom_range(0, 2047);
    end else if (pick < 55) begin
      idx = (window + $urandom_range(0, 15)) % reach;
    end else if (pick < 67) begin
      idx = reach - 1 - $urandom_range(0, (reach > 4) ? 3 : reach - 1);
    end else if (pick < 75) begin
      idx = reach + $urandom_range(0, 3);
    end else begin
      idx = $urandom_range(0, reach - 1);
    end
    issue(cmd, idx, $urandom_range(0, 255));
    if (allow_gaps && $urandom_range(0, 3) == 0) rest($urandom_range(1, 10));
    // Now and then the sender holds off until every result is back.
    if (allow_gaps && $urandom_range(0, 59) == 0) drain();
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    op <= OP_READ;
    slot <= '0;
    value <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Full byte slots: both ends of the store, a slot beyond the count, a
    // slot far beyond it, the unused op code, and a read after a clear.
    set_config(4'd8, 12'd256);
    issue(OP_WRITE, 11'd0, 8'hFF);
    issue(OP_WRITE, 11'd255, 8'hA5);
    issue(OP_READ, 11'd0, 8'h00);
    issue(OP_READ, 11'd255, 8'hFF);
    issue(OP_READ, 11'd256, 8'h00);
    rest(3);
    issue(OP_WRITE, 11'd2047, 8'h5A);
    issue(OP_NOP, 11'd2047, 8'hFF);
    issue(OP_CLEAR, 11'd0, 8'h00);
    issue(OP_READ, 11'd255, 8'h00);

    // Three-bit slots: one that straddles a byte boundary and its neighbours,
    // the last slot that fits, and the first that runs past the store.
    set_config(4'd3, 12'd4095);
    issue(OP_WRITE, 11'd2, 8'hFF);
    issue(OP_READ, 11'd2, 8'h00);
    issue(OP_READ, 11'd1, 8'h00);
    issue(OP_READ, 11'd3, 8'h00);
    issue(OP_WRITE, 11'd681, 8'hFE);
    issue(OP_READ, 11'd681, 8'h00);
    issue(OP_READ, 11'd682, 8'h00);
    issue(OP_WRITE, 11'd682, 8'hFF);

    // A width of zero counts as one, and with no slots in use every access
    // is refused.
    set_config(4'd0, 12'd0);
    issue(OP_READ, 11'd0, 8'h00);
    issue(OP_WRITE, 11'd0, 8'h01);

    // A width above eight counts as eight.
    set_config(4'd15, 12'd2048);
    issue(OP_WRITE, 11'd255, 8'h80);
    issue(OP_READ, 11'd255, 8'h00);
    issue(OP_READ, 11'd300, 8'h00);

    // Random phases, each under its own register setting. The last one runs
    // without any gaps on the sender side.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_config(4'd8, 12'd256);
        1: set_config(4'd1, 12'd4095);
        2: set_config(4'd5, MEM_BYTES * 8 / 5 - 8 + $urandom_range(0, 16));
        3: set_config($urandom_range(0, 15), $urandom_range(0, 4095));
        4: set_config(4'd7, $urandom_range(1, 40));
        default: set_config($urandom_range(1, 8), $urandom_range(0, 4095));
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) random_beat(ph != RANDOM_PHASES - 1);
    end

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
